/* sv/bcg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounding circle grower package
// Shared types and fixed constants for the bounding circle grower.
// ----------------------------------------------------------------------------

package bcg_pkg;

    // Fixed field widths of the stream ports
    localparam int POS_W       = 24;
    localparam int RADIUS_W    = 24;
    localparam int OUT_W       = 24;
    localparam int S_TDATA_W   = 2 * POS_W;
    localparam int M_TDATA_W   = 2 * OUT_W + RADIUS_W;

    localparam logic [RADIUS_W-1:0] RADIUS_MAX = 24'hFF_FFFF;
    localparam logic [RADIUS_W-1:0] RADIUS_RST = 24'd4000;

    // Item opcodes carried in tuser
    localparam logic OP_OBSERVE = 1'b0;
    localparam logic OP_RESET   = 1'b1;

    // Item sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SQR,
        ST_TEST,
        ST_ROOT,
        ST_PROD,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

/* sv/bcg_sermul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial multiplier
// Shift-add multiplier, one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------

module bcg_sermul #(
    parameter int A_W = 24,
    parameter int B_W = 25
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [A_W-1:0]     i_mcand,
    input  logic [B_W-1:0]     i_mplier,
    output logic               o_done,
    output logic [A_W+B_W-1:0] o_prod
);

    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(B_W + 1);

    logic [A_W-1:0]   r_mcand;
    logic [P_W-1:0]   r_prod;
    logic [P_W-1:0]   n_prod;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [A_W:0]     w_sum;

    // Add the multiplicand into the upper half when the current bit is set
    always_comb begin
        w_sum  = {1'b0, r_prod[P_W-1:B_W]} + (r_prod[0] ? {1'b0, r_mcand} : '0);
        n_prod = {w_sum, r_prod[B_W-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(B_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand <= i_mcand;
            r_prod  <= {{A_W{1'b0}}, i_mplier};
        end else if (r_cnt != '0) begin
            r_prod <= n_prod;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

/* sv/bcg_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial square root
// Restoring digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------

module bcg_sqrt #(
    parameter int RES_W = 25
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [2*RES_W-1:0] i_rad,
    output logic               o_done,
    output logic [RES_W-1:0]   o_root
);

    localparam int CNT_W = $clog2(RES_W + 1);

    logic [2*RES_W-1:0] r_rad;
    logic [RES_W-1:0]   r_rem;
    logic [RES_W-1:0]   r_root;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_done;
    logic [RES_W+1:0]   w_rem_sh;
    logic [RES_W+1:0]   w_trial;
    logic [RES_W+1:0]   w_diff;
    logic               w_ge;
    logic [RES_W-1:0]   n_rem;

    // Bring down two radicand bits and try the next root bit
    always_comb begin
        w_rem_sh = {r_rem, r_rad[2*RES_W-1 -: 2]};
        w_trial  = {r_root, 2'b01};
        w_ge     = (w_rem_sh >= w_trial);
        w_diff   = w_rem_sh - w_trial;
        n_rem    = w_ge ? w_diff[RES_W-1:0] : w_rem_sh[RES_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(RES_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_cnt != '0) begin
            r_rad  <= {r_rad[2*RES_W-3:0], 2'b00};
            r_rem  <= n_rem;
            r_root <= {r_root[RES_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

/* sv/bcg_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial divider
// Restoring divider, one quotient bit per cycle. The numerator must be below
// den * 2^Q_W so that the quotient fits in Q_W bits.
// ----------------------------------------------------------------------------

module bcg_div #(
    parameter int N_W = 50,
    parameter int D_W = 26,
    parameter int Q_W = 24
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_num,
    input  logic [D_W-1:0] i_den,
    output logic           o_done,
    output logic [Q_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic [D_W-1:0]   r_den;
    logic [D_W-1:0]   r_rem;
    logic [Q_W-1:0]   r_q;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [D_W:0]     w_rem_sh;
    logic [D_W:0]     w_diff;
    logic             w_ge;
    logic [D_W-1:0]   n_rem;

    // Shift in the next numerator bit and subtract when it fits
    always_comb begin
        w_rem_sh = {r_rem, r_q[Q_W-1]};
        w_ge     = (w_rem_sh >= {1'b0, r_den});
        w_diff   = w_rem_sh - {1'b0, r_den};
        n_rem    = w_ge ? w_diff[D_W-1:0] : w_rem_sh[D_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(Q_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Quotient bits fill the low end as numerator bits leave the top
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= D_W'(i_num >> Q_W);
            r_q   <= i_num[Q_W-1:0];
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_q   <= {r_q[Q_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

/* sv/bounding_circle_grow.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounding circle grower
// Keeps a 2D circle (center, radius) in 1/16 mm fixed point and grows it,
// Ritter style, to enclose each observed point; a reset item re-centers it.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake                      Payload (LSB first)
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata: pos_x, pos_y
//                                                tuser: opcode
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: center_x, center_y,
//                                                       radius
//                                                tuser: grew
//  cfg       in   i_cfg_valid / o_cfg_ready      i_cfg_data: default_radius
//
//  Each item is taken in the idle state and loaded; a reset item then goes
//  straight to the output state. An observe runs the square pass and the
//  test, and ends there when the point is inside the circle. An observe that
//  grows adds the square root, a second bit-serial multiplier pass and the
//  divider; the multiplier operand is DW = max(COORD_BITS+1, 24) bits wide.
//  Reset (synchronous, active low) centers the circle at the origin with
//  radius 4000 and loads default_radius with 4000.
//  One item is in flight at a time; a result waits in the output register,
//  so the next item is taken while m_axis is stalled, but its own result
//  holds in the output state until that register is free.
//  The config port is always ready and never touches the current radius.
// ----------------------------------------------------------------------------

module bounding_circle_grow #(
    parameter int COORD_BITS = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input items
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [bcg_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // pos_x, pos_y
    input  logic                            s_axis_tuser,  // opcode
    // Result items
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [bcg_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // center_x, center_y, radius
    output logic                            m_axis_tuser,  // grew
    // Default radius register
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bcg_pkg::RADIUS_W-1:0]    i_cfg_data
);

    localparam int CB     = COORD_BITS;
    localparam int RW     = bcg_pkg::RADIUS_W;
    localparam int PW     = bcg_pkg::POS_W;
    localparam int OW     = bcg_pkg::OUT_W;
    localparam int ROOT_W = CB + 1;
    localparam int DW     = (ROOT_W > RW) ? ROOT_W : RW;
    localparam int PROD_W = CB + DW;
    localparam int SUM_W  = 2 * CB + 1;
    localparam int R2_W   = 2 * RW;
    localparam int CMP_W  = (SUM_W > R2_W) ? SUM_W : R2_W;
    localparam int NUM_W  = PROD_W + 1;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    bcg_pkg::t_state r_state;
    bcg_pkg::t_state n_state;

    logic            r_op;
    logic [CB-1:0]   r_px;
    logic [CB-1:0]   r_py;
    logic [CB-1:0]   r_cx;
    logic [CB-1:0]   r_cy;
    logic [RW-1:0]   r_radius;
    logic [RW-1:0]   r_default_radius;
    logic [CB-1:0]   r_ax;
    logic [CB-1:0]   r_ay;
    logic            r_negx;
    logic            r_negy;
    logic [SUM_W-1:0] r_sq;
    logic [R2_W-1:0] r_r2;
    logic [DW-1:0]   r_d;
    logic            r_grew;

    logic            r_out_valid;
    logic [OW-1:0]   r_out_cx;
    logic [OW-1:0]   r_out_cy;
    logic [RW-1:0]   r_out_radius;
    logic            r_out_grew;

    // ------------------------------------------------------------------
    // Control strobes
    // ------------------------------------------------------------------
    logic c_in_ready;
    logic c_reset_load;
    logic c_sq_start;
    logic c_sq_latch;
    logic c_no_grow;
    logic c_root_start;
    logic c_prod_start;
    logic c_div_start;
    logic c_commit;
    logic c_out_load;

    // ------------------------------------------------------------------
    // Datapath wires
    // ------------------------------------------------------------------
    logic [CB-1:0]     w_in_px;
    logic [CB-1:0]     w_in_py;
    logic              w_ge_x;
    logic              w_ge_y;
    logic [CB-1:0]     w_mag_x;
    logic [CB-1:0]     w_mag_y;
    logic              w_grow;
    logic [DW-1:0]     w_d_max;
    logic [DW-1:0]     w_d_sel;
    logic [DW-1:0]     w_d_minus_r;
    logic [CB-1:0]     w_mcand_x;
    logic [CB-1:0]     w_mcand_y;
    logic [DW-1:0]     w_mpl_x;
    logic [DW-1:0]     w_mpl_y;
    logic              w_mul_start;
    logic              w_mx_done;
    logic              w_my_done;
    logic              w_mr_done;
    logic [PROD_W-1:0] w_px_prod;
    logic [PROD_W-1:0] w_py_prod;
    logic [RW+DW-1:0]  w_pr_prod;
    logic [SUM_W-1:0]  w_sq;
    logic              w_root_done;
    logic [ROOT_W-1:0] w_root;
    logic [NUM_W-1:0]  w_num_x;
    logic [NUM_W-1:0]  w_num_y;
    logic              w_dx_done;
    logic              w_dy_done;
    logic [CB-1:0]     w_qx;
    logic [CB-1:0]     w_qy;
    logic [CB-1:0]     w_new_cx;
    logic [CB-1:0]     w_new_cy;
    logic [DW:0]       w_rsum;
    logic [DW-1:0]     w_nr;
    logic [RW-1:0]     w_nr_sat;

    // Take the low COORD_BITS bits of the 24-bit positions (upper bits read
    // as zero when the coordinates are wider than the port field)
    assign w_in_px = CB'({{CB{1'b0}}, s_axis_tdata[PW-1:0]});
    assign w_in_py = CB'({{CB{1'b0}}, s_axis_tdata[2*PW-1:PW]});

    // Offset magnitudes: subtract in whichever order gives a positive value
    always_comb begin
        w_ge_x  = ($signed(r_px) >= $signed(r_cx));
        w_ge_y  = ($signed(r_py) >= $signed(r_cy));
        w_mag_x = w_ge_x ? (r_px - r_cx) : (r_cx - r_px);
        w_mag_y = w_ge_y ? (r_py - r_cy) : (r_cy - r_py);
    end

    // Grow only when r*r < dx*dx + dy*dy
    assign w_grow = (CMP_W'(r_r2) < CMP_W'(r_sq));

    assign w_sq = SUM_W'(w_px_prod[2*CB-1:0]) + SUM_W'(w_py_prod[2*CB-1:0]);

    // d = max(floor(sqrt(S)), r), and never zero
    always_comb begin
        w_d_max     = (DW'(w_root) > DW'(r_radius)) ? DW'(w_root) : DW'(r_radius);
        w_d_sel     = (w_d_max == '0) ? DW'(1) : w_d_max;
        w_d_minus_r = w_d_sel - DW'(r_radius);
    end

    // First multiplier pass squares the offsets, the second forms |D|*(d-r)
    always_comb begin
        w_mul_start = c_sq_start || c_prod_start;
        w_mcand_x   = c_sq_start ? w_mag_x : r_ax;
        w_mcand_y   = c_sq_start ? w_mag_y : r_ay;
        w_mpl_x     = c_sq_start ? DW'(w_mag_x) : w_d_minus_r;
        w_mpl_y     = c_sq_start ? DW'(w_mag_y) : w_d_minus_r;
    end

    // Center step numerator |D|*(d-r) + d, over 2d: rounds half away from zero
    assign w_num_x = NUM_W'(w_px_prod) + NUM_W'(r_d);
    assign w_num_y = NUM_W'(w_py_prod) + NUM_W'(r_d);

    always_comb begin
        w_new_cx = r_negx ? (r_cx - w_qx) : (r_cx + w_qx);
        w_new_cy = r_negy ? (r_cy - w_qy) : (r_cy + w_qy);
        w_rsum   = (DW + 1)'(r_d) + (DW + 1)'(r_radius) + (DW + 1)'(1);
        w_nr     = w_rsum[DW:1];
        w_nr_sat = (w_nr > DW'(bcg_pkg::RADIUS_MAX)) ? bcg_pkg::RADIUS_MAX : RW'(w_nr);
    end

    // ------------------------------------------------------------------
    // Serial units
    // ------------------------------------------------------------------
    bcg_sermul #(.A_W(CB), .B_W(DW)) u_mul_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mul_start),
        .i_mcand  (w_mcand_x),
        .i_mplier (w_mpl_x),
        .o_done   (w_mx_done),
        .o_prod   (w_px_prod)
    );

    bcg_sermul #(.A_W(CB), .B_W(DW)) u_mul_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mul_start),
        .i_mcand  (w_mcand_y),
        .i_mplier (w_mpl_y),
        .o_done   (w_my_done),
        .o_prod   (w_py_prod)
    );

    // Radius square runs beside the offset squares, same length
    bcg_sermul #(.A_W(RW), .B_W(DW)) u_mul_r (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (c_sq_start),
        .i_mcand  (r_radius),
        .i_mplier (DW'(r_radius)),
        .o_done   (w_mr_done),
        .o_prod   (w_pr_prod)
    );

    bcg_sqrt #(.RES_W(ROOT_W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (c_root_start),
        .i_rad   ((2 * ROOT_W)'(r_sq)),
        .o_done  (w_root_done),
        .o_root  (w_root)
    );

    bcg_div #(.N_W(NUM_W), .D_W(DW + 1), .Q_W(CB)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (c_div_start),
        .i_num   (w_num_x),
        .i_den   ({r_d, 1'b0}),
        .o_done  (w_dx_done),
        .o_quo   (w_qx)
    );

    bcg_div #(.N_W(NUM_W), .D_W(DW + 1), .Q_W(CB)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (c_div_start),
        .i_num   (w_num_y),
        .i_den   ({r_d, 1'b0}),
        .o_done  (w_dy_done),
        .o_quo   (w_qy)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bcg_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = bcg_pkg::ST_LOAD;
                end
            end
            bcg_pkg::ST_LOAD: begin
                if (r_op == bcg_pkg::OP_RESET) begin
                    n_state = bcg_pkg::ST_OUT;
                end else begin
                    n_state = bcg_pkg::ST_SQR;
                end
            end
            bcg_pkg::ST_SQR: begin
                if (w_mx_done) begin
                    n_state = bcg_pkg::ST_TEST;
                end
            end
            bcg_pkg::ST_TEST: begin
                if (w_grow) begin
                    n_state = bcg_pkg::ST_ROOT;
                end else begin
                    n_state = bcg_pkg::ST_OUT;
                end
            end
            bcg_pkg::ST_ROOT: begin
                if (w_root_done) begin
                    n_state = bcg_pkg::ST_PROD;
                end
            end
            bcg_pkg::ST_PROD: begin
                if (w_mx_done) begin
                    n_state = bcg_pkg::ST_DIV;
                end
            end
            bcg_pkg::ST_DIV: begin
                if (w_dx_done) begin
                    n_state = bcg_pkg::ST_OUT;
                end
            end
            bcg_pkg::ST_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = bcg_pkg::ST_IDLE;
                end
            end
            default: n_state = bcg_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        c_in_ready   = 1'b0;
        c_reset_load = 1'b0;
        c_sq_start   = 1'b0;
        c_sq_latch   = 1'b0;
        c_no_grow    = 1'b0;
        c_root_start = 1'b0;
        c_prod_start = 1'b0;
        c_div_start  = 1'b0;
        c_commit     = 1'b0;
        c_out_load   = 1'b0;
        unique case (r_state)
            bcg_pkg::ST_IDLE: c_in_ready = 1'b1;
            bcg_pkg::ST_LOAD: begin
                c_reset_load = (r_op == bcg_pkg::OP_RESET);
                c_sq_start   = (r_op == bcg_pkg::OP_OBSERVE);
            end
            bcg_pkg::ST_SQR:  c_sq_latch = w_mx_done;
            bcg_pkg::ST_TEST: begin
                c_root_start = w_grow;
                c_no_grow    = !w_grow;
            end
            bcg_pkg::ST_ROOT: c_prod_start = w_root_done;
            bcg_pkg::ST_PROD: c_div_start  = w_mx_done;
            bcg_pkg::ST_DIV:  c_commit     = w_dx_done;
            bcg_pkg::ST_OUT:  c_out_load   = !r_out_valid || m_axis_tready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bcg_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Circle state and default radius
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx             <= '0;
            r_cy             <= '0;
            r_radius         <= bcg_pkg::RADIUS_RST;
            r_default_radius <= bcg_pkg::RADIUS_RST;
        end else begin
            if (i_cfg_valid) begin
                r_default_radius <= i_cfg_data;
            end
            if (c_reset_load) begin
                // Re-center at the given position with the default radius
                r_cx     <= r_px;
                r_cy     <= r_py;
                r_radius <= r_default_radius;
            end else if (c_commit) begin
                r_cx     <= w_new_cx;
                r_cy     <= w_new_cy;
                r_radius <= w_nr_sat;
            end
        end
    end

    // Working registers of one item
    always_ff @(posedge i_clk) begin
        if (c_in_ready && s_axis_tvalid) begin
            r_op <= s_axis_tuser;
            r_px <= w_in_px;
            r_py <= w_in_py;
        end
        if (c_sq_start) begin
            r_ax   <= w_mag_x;
            r_ay   <= w_mag_y;
            r_negx <= !w_ge_x;
            r_negy <= !w_ge_y;
        end
        if (c_sq_latch) begin
            r_sq <= w_sq;
            r_r2 <= w_pr_prod[R2_W-1:0];
        end
        if (c_prod_start) begin
            r_d <= w_d_sel;
        end
        if (c_reset_load || c_no_grow) begin
            r_grew <= 1'b0;
        end else if (c_commit) begin
            r_grew <= 1'b1;
        end
    end

    // Output register: hold a result until m_axis takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (c_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_out_load) begin
            // Sign extend narrow centers, drop the top of wide ones
            r_out_cx     <= OW'({{OW{r_cx[CB-1]}}, r_cx});
            r_out_cy     <= OW'({{OW{r_cy[CB-1]}}, r_cy});
            r_out_radius <= r_radius;
            r_out_grew   <= r_grew;
        end
    end

    assign s_axis_tready = c_in_ready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_radius, r_out_cy, r_out_cx};
    assign m_axis_tuser  = r_out_grew;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Square pass: all three multipliers finish together
    a_sqr_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bcg_pkg::ST_SQR) |->
            ((w_mx_done == w_my_done) && (w_mx_done == w_mr_done)))
        else $error("square multipliers out of step");

    // Center step never passes the observed point
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bcg_pkg::ST_DIV && w_dx_done) |->
            (w_dy_done && (w_qx <= r_ax) && (w_qy <= r_ay)))
        else $error("center step exceeds offset");

    // Growth never shrinks the radius
    a_radius_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_commit |=> (r_radius >= $past(r_radius)))
        else $error("radius decreased on growth");

endmodule

/* bench/circle_track_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounding circle tracking check
// Watches the item, result and register channels of the bounding circle
// grower, keeps its own circle and default radius, and compares each result
// transfer field by field with the oldest predicted circle.
// ----------------------------------------------------------------------------

module circle_track_check #(
    parameter int COORD_BITS = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [bcg_pkg::S_TDATA_W-1:0]   s_axis_tdata,   // pos_x, pos_y
    input  logic                            s_axis_tuser,   // opcode
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [bcg_pkg::M_TDATA_W-1:0]   m_axis_tdata,   // center_x, center_y, radius
    input  logic                            m_axis_tuser,   // grew
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [bcg_pkg::RADIUS_W-1:0]    i_cfg_data,
    output int                              o_fail_cnt,
    output int                              o_pending
);

    import bcg_pkg::*;

    localparam int PRINT_CAP = 40;

    typedef struct packed {
        logic [OUT_W-1:0]    cx;
        logic [OUT_W-1:0]    cy;
        logic [RADIUS_W-1:0] radius;
        logic                grew;
    } circle_t;

    logic [COORD_BITS-1:0] ctr_x;
    logic [COORD_BITS-1:0] ctr_y;
    logic [RADIUS_W-1:0]   rad;
    logic [RADIUS_W-1:0]   dflt_rad;
    circle_t               due_circles[$];
    int                    fails = 0;

    assign o_fail_cnt = fails;

    // Sign extend from bit COORD_BITS-1
    function automatic logic signed [63:0] widen(input logic [63:0] v);
        logic [63:0] m;
        m = (64'd1 << COORD_BITS) - 64'd1;
        v = v & m;
        if (v[COORD_BITS-1])
            return $signed(v | ~m);
        return $signed(v);
    endfunction

    function automatic logic [63:0] root_floor(input logic [127:0] s);
        logic [127:0] acc;
        logic [127:0] cand;
        acc = '0;
        for (int b = 33; b >= 0; b--) begin
            cand = acc | (128'd1 << b);
            if (cand * cand <= s)
                acc = cand;
        end
        return acc[63:0];
    endfunction

    // Move toward the point by |D|*(d-r)/(2d), rounded half away from zero
    function automatic logic signed [63:0] center_step(input logic signed [63:0] diff,
                                                       input logic [127:0] d,
                                                       input logic [127:0] r);
        logic [127:0] mag;
        logic [127:0] q;
        mag = {64'd0, (diff[63] ? -diff : diff)};
        q   = (mag * (d - r) + d) / (d << 1);
        return diff[63] ? -$signed(q[63:0]) : $signed(q[63:0]);
    endfunction

    task automatic grow_circle(input logic op, input logic [POS_W-1:0] px_in,
                               input logic [POS_W-1:0] py_in, output circle_t res);
        logic signed [63:0] px, py, cx, cy, dx, dy;
        logic [127:0]       ax, ay, s, r, d, nr;
        px = widen({{(64-POS_W){1'b0}}, px_in});
        py = widen({{(64-POS_W){1'b0}}, py_in});
        res.grew = 1'b0;
        if (op == OP_RESET) begin
            ctr_x = px[COORD_BITS-1:0];
            ctr_y = py[COORD_BITS-1:0];
            rad   = dflt_rad;
        end else begin
            cx = widen({{(64-COORD_BITS){1'b0}}, ctr_x});
            cy = widen({{(64-COORD_BITS){1'b0}}, ctr_y});
            dx = px - cx;
            dy = py - cy;
            ax = {64'd0, (dx[63] ? -dx : dx)};
            ay = {64'd0, (dy[63] ? -dy : dy)};
            s  = ax * ax + ay * ay;
            r  = {{(128-RADIUS_W){1'b0}}, rad};
            if (r * r < s) begin
                d = {64'd0, root_floor(s)};
                if (d < r)
                    d = r;
                if (d == 0)
                    d = 1;
                cx    = cx + center_step(dx, d, r);
                cy    = cy + center_step(dy, d, r);
                ctr_x = cx[COORD_BITS-1:0];
                ctr_y = cy[COORD_BITS-1:0];
                nr    = (d + r + 1) >> 1;
                rad   = (nr > RADIUS_MAX) ? RADIUS_MAX : nr[RADIUS_W-1:0];
                res.grew = 1'b1;
            end
        end
        cx = widen({{(64-COORD_BITS){1'b0}}, ctr_x});
        cy = widen({{(64-COORD_BITS){1'b0}}, ctr_y});
        res.cx     = cx[OUT_W-1:0];
        res.cy     = cy[OUT_W-1:0];
        res.radius = rad;
    endtask

    task automatic report_miss(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (fails < PRINT_CAP)
            $display("circle check: %s got %0h expected %0h at %0t", what, got, want, $time);
        fails++;
    endtask

    always @(posedge i_clk) begin : watch
        circle_t want;
        circle_t got;
        if (!i_rst_n) begin
            ctr_x    = '0;
            ctr_y    = '0;
            rad      = RADIUS_RST;
            dflt_rad = RADIUS_RST;
            due_circles.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                dflt_rad = i_cfg_data;
            if (s_axis_tvalid && s_axis_tready) begin
                grow_circle(s_axis_tuser, s_axis_tdata[POS_W-1:0],
                            s_axis_tdata[2*POS_W-1:POS_W], want);
                due_circles.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.cx     = m_axis_tdata[OUT_W-1:0];
                got.cy     = m_axis_tdata[2*OUT_W-1:OUT_W];
                got.radius = m_axis_tdata[2*OUT_W+RADIUS_W-1:2*OUT_W];
                got.grew   = m_axis_tuser;
                if (due_circles.size() == 0) begin
                    report_miss("result with nothing due, radius", 32'(got.radius), '0);
                end else begin
                    want = due_circles.pop_front();
                    if (got.cx !== want.cx)
                        report_miss("center_x", 32'(got.cx), 32'(want.cx));
                    if (got.cy !== want.cy)
                        report_miss("center_y", 32'(got.cy), 32'(want.cy));
                    if (got.radius !== want.radius)
                        report_miss("radius", 32'(got.radius), 32'(want.radius));
                    if (got.grew !== want.grew)
                        report_miss("grew", 32'(got.grew), 32'(want.grew));
                end
            end
        end
        o_pending <= due_circles.size();
    end

endmodule

/* bench/bounding_circle_grow_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounding circle grower testbench
// Drives observe and reset items into the grower, rewrites the default radius
// between phases, and lets a tracking check predict and compare every result.
// A directed opening covers the corner cases; random phases follow with
// clustered point runs, noise, random idling on both sides and a long
// receiver hold-off.
// ----------------------------------------------------------------------------

module bounding_circle_grow_tb;

    import bcg_pkg::*;

    localparam int COORD_BITS  = 24;
    localparam int CLK_HALF    = 4;
    localparam int RAND_ITEMS  = 1600;
    localparam int N_PHASES    = 6;
    localparam int HOLD_CYCLES = 1000;
    localparam int TAIL_CYCLES = 150;     // a bit more than the slowest item
    localparam int LIMIT       = 3000000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata;   // pos_x, pos_y
    logic                   s_axis_tuser;   // opcode
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [M_TDATA_W-1:0]   m_axis_tdata;   // center_x, center_y, radius
    logic                   m_axis_tuser;   // grew
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [RADIUS_W-1:0]    i_cfg_data;

    int fail_cnt;
    int due_cnt;
    int cycle_cnt = 0;
    int hold_reqs;      // bumped by the stimulus to request a receiver hold-off
    bit src_idle_en;
    bit sink_idle_en;

    bounding_circle_grow #(
        .COORD_BITS (COORD_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    circle_track_check #(
        .COORD_BITS (COORD_BITS)
    ) u_track_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_fail_cnt    (fail_cnt),
        .o_pending     (due_cnt)
    );

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    // Guard against a hung handshake: end the run as a failure
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT) begin
            $display("bounding_circle_grow_tb: FAIL");
            $finish;
        end
    end

    // Result receiver. Drop tready at random while idling is on; on each new
    // hold-off request, hold it low for a fixed stretch of cycles so the
    // output register and the working item both fill and the input stalls.
    initial begin : sink
        int hold_served;
        hold_served   = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_served != hold_reqs) begin
                hold_served = hold_reqs;
                m_axis_tready <= 1'b0;
                for (int k = 1; k < HOLD_CYCLES; k++)
                    @(negedge i_clk);
            end else begin
                m_axis_tready <= !(sink_idle_en && ($urandom_range(99) < 30));
            end
        end
    end

    // Offer one item and return at the falling edge after its transfer.
    // Idle first, mostly for short random gaps, sometimes for a long one so
    // that gaps land on every stage of the block's growth computation.
    task automatic push_item(input logic op, input logic [POS_W-1:0] px,
                             input logic [POS_W-1:0] py);
        int gap;
        gap = 0;
        if (src_idle_en) begin
            if ($urandom_range(99) < 10)
                gap = $urandom_range(1, 120);
            else
                while ($urandom_range(99) < 30)
                    gap++;
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {py, px};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // Stop offering and wait until every predicted circle has come back
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        wait (due_cnt == 0);
        @(negedge i_clk);
    endtask

    // Write the default radius; call only while the block is idle
    task automatic set_default(input logic [RADIUS_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [POS_W-1:0] jitter(input logic [POS_W-1:0] base,
                                                input int spread);
        int off;
        off = $urandom_range(0, 2 * spread);
        off = off - spread;
        return base + off[POS_W-1:0];
    endfunction

    // One random phase. Most of it is runs of points scattered around a
    // re-centered circle at a random scale, so that circles grow, hold and
    // saturate; the rest is noise items and runs without a leading reset.
    task automatic run_phase(input int n_items, input int hold_at);
        int               sent;
        int               spread;
        logic [POS_W-1:0] base_x;
        logic [POS_W-1:0] base_y;
        sent = 0;
        while (sent < n_items) begin
            if (sent >= hold_at && hold_at >= 0) begin
                hold_reqs <= hold_reqs + 1;
                hold_at = -1;
            end
            if ($urandom_range(99) < 15) begin
                push_item(1'($urandom_range(1)), POS_W'($urandom), POS_W'($urandom));
                sent++;
            end else begin
                spread = ($urandom_range(1) != 0) ? 4096 : 8388607;
                base_x = jitter('0, spread);
                base_y = jitter('0, spread);
                if ($urandom_range(99) < 80) begin
                    push_item(OP_RESET, base_x, base_y);
                    sent++;
                end
                spread = 1 << $urandom_range(0, 23);
                repeat ($urandom_range(3, 16)) begin
                    if ($urandom_range(99) < 8)
                        push_item(OP_OBSERVE, POS_W'($urandom), POS_W'($urandom));
                    else
                        push_item(OP_OBSERVE, jitter(base_x, spread), jitter(base_y, spread));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_OBSERVE;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        i_rst_n       = 1'b0;
        hold_reqs     = 0;
        src_idle_en   = 1'b1;
        sink_idle_en  = 1'b1;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: circle at the origin with the reset radius of 4000.
        // Inside, exactly on the rim, then just outside.
        push_item(OP_OBSERVE, 24'd100, -24'sd100);
        push_item(OP_OBSERVE, 24'd4000, 24'd0);
        push_item(OP_OBSERVE, 24'd0, -24'sd4001);
        // Re-center at opposite corners of the coordinate range and grow big
        push_item(OP_RESET, 24'h7F_FFFF, 24'h80_0000);
        push_item(OP_OBSERVE, 24'h80_0000, 24'h7F_FFFF);
        push_item(OP_OBSERVE, 24'd0, 24'd0);

        // A new default must leave the current radius alone until a reset
        settle();
        set_default(24'd5);
        push_item(OP_OBSERVE, 24'd1, 24'd1);
        push_item(OP_RESET, 24'd0, 24'd0);
        // Just outside with the truncated distance equal to the radius
        push_item(OP_OBSERVE, 24'd5, 24'd1);
        push_item(OP_OBSERVE, 24'd3, 24'd4);

        // Zero radius: the center itself is inside, one step away grows
        settle();
        set_default(24'd0);
        push_item(OP_RESET, 24'hFF_FFFF, 24'hFF_FFFF);
        push_item(OP_OBSERVE, 24'hFF_FFFF, 24'hFF_FFFF);
        push_item(OP_OBSERVE, 24'd0, 24'hFF_FFFF);
        push_item(OP_OBSERVE, 24'h80_0000, 24'h80_0000);

        // Largest radius: a diagonal point forces saturation
        settle();
        set_default(RADIUS_MAX);
        push_item(OP_RESET, 24'h80_0000, 24'h80_0000);
        push_item(OP_OBSERVE, 24'h7F_FFFF, 24'h7F_FFFF);
        push_item(OP_OBSERVE, 24'h80_0000, 24'h7F_FFFF);
        push_item(OP_RESET, 24'h7F_FFFF, 24'h7F_FFFF);
        push_item(OP_OBSERVE, 24'h80_0000, 24'h80_0000);
        push_item(OP_OBSERVE, 24'hFF_FFFF, 24'd0);

        // Random phases, each with its own default radius. Phase two runs
        // with no idling on either side; phase three holds the receiver off.
        for (int p = 0; p < N_PHASES; p++) begin
            settle();
            case (p)
                0: set_default(24'd0);
                1: set_default(RADIUS_RST);
                2: set_default(RADIUS_W'($urandom_range(0, 65535)));
                3: set_default(RADIUS_MAX);
                4: set_default(24'd1);
                default: set_default(RADIUS_W'($urandom));
            endcase
            src_idle_en  <= (p != 1);
            sink_idle_en <= (p != 1);
            run_phase(RAND_ITEMS / N_PHASES, (p == 2) ? 40 : -1);
        end

        settle();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_cnt == 0)
            $display("bounding_circle_grow_tb: PASS");
        else
            $display("bounding_circle_grow_tb: FAIL");
        $finish;
    end

endmodule
